### rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Word layouts, opcodes, sequencer states and datapath sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int FW              = 32;  // field width of every operand part
  localparam int XW              = 65;  // exact result width (sum of two products)
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int UNIT_STEPS      = FW;  // one bit per cycle in the shared unit
  localparam int CNT_W           = $clog2(UNIT_STEPS);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_RED = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_POST,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]           opcode;
    logic signed [FW-1:0] a_num;
    logic signed [FW-1:0] a_den;
    logic signed [FW-1:0] b_num;
    logic signed [FW-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [FW-1:0] res_num;
    logic signed [FW-1:0] res_den;
    logic                 overflow;
    logic                 zero_fraction;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply, divide and reduce fractions
// Sequenced datapath around one shared 34-bit add/subtract unit.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall / in_word) takes one word holding
//   an opcode and two fractions. The output channel (out_valid / out_stall /
//   out_word) returns one fraction plus overflow and zero_fraction flags.
//   A word is taken on a rising edge with valid high and stall low.
//   Every product and every division runs on one shared add/subtract unit,
//   one bit per cycle, with a start and a post step around each pass:
//     add, subtract, multiply, divide: 3 products.
//     reduce: one division per Euclid step plus two for the quotients;
//       0/0 and unused opcodes skip the passes.
//   The Euclid loop on the divider sets the reduce latency.
//   in_stall is high while a word is being worked on; one word at a time.
//   The result sits in an output register, so a new word is accepted while
//   the previous result still waits; the sequencer holds in its final step
//   only if that register is still full and stalled.
//   Reset (synchronous, rst_n low) returns the sequencer to idle and empties
//   the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rau_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rau_pkg::out_word_t      out_word
);

  import rau_pkg::*;

  // operands are sign-extended from this width
  localparam int IW = (VALUE_WIDTH < FW) ? VALUE_WIDTH : FW;

  // exact value fits a signed VALUE_WIDTH word
  function automatic logic fits_w(input logic signed [XW-1:0] v);
    logic signed [VALUE_WIDTH-1:0] t;
    t = v[VALUE_WIDTH-1:0];
    return v == XW'(t);
  endfunction

  // wrap to VALUE_WIDTH, present in a 32-bit field
  function automatic logic [FW-1:0] wrap_w(input logic signed [XW-1:0] v);
    logic signed [VALUE_WIDTH-1:0] t;
    logic signed [XW-1:0]          e;
    t = v[VALUE_WIDTH-1:0];
    e = XW'(t);
    return e[FW-1:0];
  endfunction

  function automatic logic signed [FW-1:0] sext_in(input logic [FW-1:0] raw);
    logic signed [IW-1:0] t;
    t = raw[IW-1:0];
    return FW'(t);
  endfunction

  function automatic logic [FW-1:0] mag(input logic signed [FW-1:0] v);
    return v[FW-1] ? FW'(-v) : FW'(v);
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  logic [1:0]            step_r, step_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [FW-1:0]         hi_r, hi_nxt;     // product high half / remainder
  logic [FW-1:0]         lo_r, lo_nxt;     // multiplier, product low / quotient
  logic [FW-1:0]         opnd_r, opnd_nxt; // multiplicand or divisor
  logic                  msign_r, msign_nxt;
  logic [2:0]            op_r;
  logic signed [FW-1:0]  an_r, ad_r, bn_r, bd_r;
  logic [FW-1:0]         x_r, x_nxt, y_r, y_nxt;   // Euclid pair
  logic signed [2*FW-1:0] p_r [3];
  logic signed [2*FW-1:0] prod_s;
  logic [FW-1:0]         qn_r, qn_nxt;
  out_word_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  in_acc, out_free, div_mode, zero_zero, unit_done;
  logic [FW-1:0]         mn, md;
  logic signed [FW-1:0]  sa, sb;
  logic [FW+1:0]         add_a, add_b, add_s;
  logic [FW:0]           rem_sh;
  logic signed [XW-1:0]  ex_num, ex_den;
  logic                  red_neg;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign div_mode  = (op_r == OP_RED);
  assign mn        = mag(an_r);
  assign md        = mag(ad_r);
  assign zero_zero = (mn == '0) && (md == '0);
  assign unit_done = (cnt_r == CNT_W'(UNIT_STEPS - 1));

  // multiply operand selection per opcode and step
  always_comb begin
    sa = '0;
    sb = '0;
    unique case (step_r)
      2'd0: begin
        sa = an_r;
        sb = (op_r == OP_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        if (op_r == OP_ADD || op_r == OP_SUB) begin
          sa = bn_r;
          sb = ad_r;
        end
      end
      default: begin
        sa = ad_r;
        sb = (op_r == OP_DIV) ? bn_r : bd_r;
      end
    endcase
  end

  // shared add/subtract unit
  assign rem_sh = {hi_r, lo_r[FW-1]};
  always_comb begin
    if (div_mode) begin
      add_a = {1'b0, rem_sh};
      add_b = {2'b00, opnd_r};
      add_s = add_a - add_b;
    end else begin
      add_a = {2'b00, hi_r};
      add_b = lo_r[0] ? {2'b00, opnd_r} : '0;
      add_s = add_a + add_b;
    end
  end

  assign prod_s = msign_r ? -$signed({hi_r, lo_r}) : $signed({hi_r, lo_r});

  // exact results at the end
  assign red_neg = (an_r[FW-1] != ad_r[FW-1]) && (qn_r != '0);
  always_comb begin
    ex_num = '0;
    ex_den = '0;
    case (op_t'(op_r)) inside
      OP_ADD: begin
        ex_num = XW'(p_r[0]) + XW'(p_r[1]);
        ex_den = XW'(p_r[2]);
      end
      OP_SUB: begin
        ex_num = XW'(p_r[0]) - XW'(p_r[1]);
        ex_den = XW'(p_r[2]);
      end
      OP_MUL, OP_DIV: begin
        ex_num = XW'(p_r[0]);
        ex_den = XW'(p_r[2]);
      end
      OP_RED: begin
        if (zero_zero) begin
          ex_num = XW'(an_r);
          ex_den = XW'(ad_r);
        end else begin
          ex_num = red_neg ? -$signed(XW'(qn_r)) : $signed(XW'(qn_r));
          ex_den = $signed(XW'(lo_r));  // qd from the last division
        end
      end
      default: begin
        ex_num = '0;
        ex_den = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_START;
      ST_START: begin
        if (op_r == OP_RED) begin
          if (zero_zero) state_nxt = ST_FIN;
          else if (step_r == 2'd0 && y_r == '0) state_nxt = ST_START;
          else state_nxt = ST_RUN;
        end else if (op_r > OP_RED) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN:   if (unit_done) state_nxt = ST_POST;
      ST_POST: begin
        if (step_r == 2'd2) state_nxt = ST_FIN;
        else state_nxt = ST_START;
      end
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath updates
  // --------------------------------------------------------------------------
  always_comb begin
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    opnd_nxt      = opnd_r;
    msign_nxt     = msign_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    qn_nxt        = qn_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = 2'd0;
        x_nxt    = mag(sext_in(in_word.a_num));
        y_nxt    = mag(sext_in(in_word.a_den));
      end
      ST_START: begin
        cnt_nxt = '0;
        hi_nxt  = '0;
        if (op_r == OP_RED) begin
          unique case (step_r)
            2'd0: begin
              if (y_r == '0) begin
                step_nxt = 2'd1;     // x_r now holds the gcd
              end else begin
                lo_nxt   = x_r;
                opnd_nxt = y_r;
              end
            end
            2'd1: begin
              lo_nxt   = mn;
              opnd_nxt = x_r;
            end
            default: begin
              lo_nxt   = md;
              opnd_nxt = x_r;
            end
          endcase
        end else begin
          lo_nxt    = mag(sa);
          opnd_nxt  = mag(sb);
          msign_nxt = sa[FW-1] ^ sb[FW-1];
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (div_mode) begin
          hi_nxt = add_s[FW+1] ? rem_sh[FW-1:0] : add_s[FW-1:0];
          lo_nxt = {lo_r[FW-2:0], !add_s[FW+1]};
        end else begin
          hi_nxt = add_s[FW:1];
          lo_nxt = {add_s[0], lo_r[FW-1:1]};
        end
      end
      ST_POST: begin
        if (step_r != 2'd2) step_nxt = step_r + 1'b1;
        if (div_mode) begin
          unique case (step_r)
            2'd0: begin
              x_nxt    = y_r;
              y_nxt    = hi_r;
              step_nxt = 2'd0;
            end
            2'd1:    qn_nxt = lo_r;
            default: ;
          endcase
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.res_num       = wrap_w(ex_num);
          out_nxt.res_den       = wrap_w(ex_den);
          out_nxt.overflow      = !fits_w(ex_num) || !fits_w(ex_den);
          out_nxt.zero_fraction = (op_r == OP_RED) && zero_zero;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= 2'd0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
    opnd_r  <= opnd_nxt;
    msign_r <= msign_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    qn_r    <= qn_nxt;
    out_r   <= out_nxt;
    if (in_acc) begin
      op_r <= in_word.opcode;
      an_r <= sext_in(in_word.a_num);
      ad_r <= sext_in(in_word.a_den);
      bn_r <= sext_in(in_word.b_num);
      bd_r <= sext_in(in_word.b_den);
    end
    if (state_r == ST_POST && !div_mode) p_r[step_r] <= prod_s;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_START)
    else $error("accepted word did not start the sequencer");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result appeared outside the final step");

  a_zf_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.zero_fraction |-> !out_r.overflow)
    else $error("zero fraction flagged with overflow");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> step_r != 2'd3)
    else $error("step counter out of range");

endmodule

`default_nettype wire

### bench/rational_arithmetic_unit_test.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test: self-checking bench for the fraction unit
// Sends directed and random words, predicts each result in the bench, and
// compares every output word field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rational_arithmetic_unit_test;
  import rau_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // results still owed by the unit, oldest first
  out_word_t pending_results[$];
  int        mismatches = 0;
  int        idle_pct = 27;  // chance in a hundred of a gap or a stall

  rational_arithmetic_unit #(.VALUE_WIDTH(VW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Wrap an exact value to the value width, presented in 32 bits.
  function automatic logic [31:0] wrap_part(input logic signed [127:0] v);
    logic signed [127:0] s;
    s = (v <<< (128 - VW)) >>> (128 - VW);
    return s[31:0];
  endfunction

  // True when an exact part does not fit a signed value-width number.
  function automatic bit out_of_range(input logic signed [127:0] v);
    logic signed [127:0] lim;
    lim = 128'sd1 <<< (VW - 1);
    return (v >= lim) || (v < -lim);
  endfunction

  // Expected fraction for one word. Operands are taken at min(VW,32) bits.
  function automatic out_word_t fraction_result(input in_word_t w);
    out_word_t r;
    logic signed [127:0] an, ad, bn, bd, pn, pd, mn, md, x, y, t, g, qn, qd;
    bit neg;
    r = '0;
    an = w.a_num; ad = w.a_den; bn = w.b_num; bd = w.b_den;
    case (w.opcode) inside
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        case (w.opcode)
          OP_ADD: begin pn = an * bd + bn * ad; pd = ad * bd; end
          OP_SUB: begin pn = an * bd - bn * ad; pd = ad * bd; end
          OP_MUL: begin pn = an * bn; pd = ad * bd; end
          default: begin pn = an * bd; pd = ad * bn; end
        endcase
        r.res_num = wrap_part(pn);
        r.res_den = wrap_part(pd);
        r.overflow = out_of_range(pn) || out_of_range(pd);
      end
      OP_RED: begin
        mn = (an < 0) ? -an : an;
        md = (ad < 0) ? -ad : ad;
        if (mn == 0 && md == 0) begin
          // no gcd for 0/0: pass through and flag it
          r.res_num = w.a_num;
          r.res_den = w.a_den;
          r.zero_fraction = 1'b1;
        end else begin
          x = mn; y = md;
          while (y != 0) begin
            t = y; y = x % y; x = t;
          end
          g = x;
          qn = mn / g; qd = md / g;
          neg = ((an < 0) != (ad < 0)) && qn != 0;
          if (neg) qn = -qn;
          r.res_num = wrap_part(qn);
          r.res_den = wrap_part(qd);
          r.overflow = out_of_range(qn) || out_of_range(qd);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Send one word; valid stays up with a fixed payload while stalled.
  // Valid drops only in a gap, so back-to-back words keep it high.
  task automatic send_word(input logic [2:0] op, input logic [31:0] an,
                           input logic [31:0] ad, input logic [31:0] bn,
                           input logic [31:0] bd);
    in_word_t w;
    w.opcode = op; w.a_num = an; w.a_den = ad; w.b_num = bn; w.b_den = bd;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(fraction_result(w));
    @(negedge clk);
  endtask

  // Receiver: random stalls, set at the falling edge.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < idle_pct);

  // Checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word %h", out_word);
      end else begin
        out_word_t e;
        e = pending_results.pop_front();
        if (e.res_num !== out_word.res_num || e.res_den !== out_word.res_den ||
            e.overflow !== out_word.overflow ||
            e.zero_fraction !== out_word.zero_fraction) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d ov%b zf%b got %0d/%0d ov%b zf%b",
                     e.res_num, e.res_den, e.overflow, e.zero_fraction,
                     out_word.res_num, out_word.res_den, out_word.overflow,
                     out_word.zero_fraction);
        end
      end
    end
  end

  // A random operand part: mostly small magnitudes, sometimes full range
  // (with 7FFF_FFFF and 8000_0001 picked out), sometimes zero.
  function automatic logic [31:0] rand_part();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return $urandom;
      3:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0001;
      default: return $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  task automatic test_arith_extremes();
    logic [31:0] vals[6];
    vals = '{32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'd0,
             32'd1, 32'hFFFF_FFFF};
    foreach (vals[i])
      send_word(3'(int'(OP_ADD) + (i % 4)), vals[i], vals[(i + 1) % 6],
                vals[(i + 2) % 6], vals[(i + 3) % 6]);
    send_word(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_word(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
    send_word(OP_MUL, 32'hFFFF_FFFE, 32'd3, 32'd5, 32'd0);   // zero denominator
    send_word(OP_DIV, 32'd7, 32'd3, 32'd0, 32'd4);           // divide by zero
  endtask

  task automatic test_reduce_cases();
    send_word(OP_RED, 32'd0, 32'd0, 32'd9, 32'd9);             // 0/0
    send_word(OP_RED, 32'hFFFF_FFF9, 32'd0, 32'd0, 32'd0);     // -7/0
    send_word(OP_RED, 32'd0, 32'hFFFF_FFFB, 32'd0, 32'd0);     // 0/-5
    send_word(OP_RED, 32'd12, 32'hFFFF_FFF8, 32'd0, 32'd0);    // sign moves
    send_word(OP_RED, 32'h8000_0000, 32'd1, 32'd0, 32'd0);     // min value
    send_word(OP_RED, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_word(OP_RED, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'd0, 32'd0);
    send_word(3'd5, 32'd1, 32'd1, 32'd1, 32'd1);               // unused opcodes
    send_word(3'd7, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
  endtask

  task automatic test_random_words(input int count);
    logic [2:0]  op;
    for (int i = 0; i < count; i++) begin
      // quiet stretch with no gaps or stalls in the middle of the run
      idle_pct = (i >= count / 3 && i < count / 2) ? 0 : 27;
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                     : 3'($urandom_range(4));
      send_word(op, rand_part(), rand_part(), rand_part(), rand_part());
    end
    idle_pct = 27;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_arith_extremes();
    test_reduce_cases();
    test_random_words(380);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // reduce can take up to ~48 Euclid steps, one division each
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
